@@ hdl/assert_macros.svh @@
// Assertion helpers, clocked on i_clk and quiet while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("assertion failed");

`endif

@@ hdl/tbu_pkg.sv @@
package tbu_pkg;

    localparam int STATE_BITS  = 4;
    localparam int TABLE_SIZE  = 1 << STATE_BITS;
    localparam int NUM_SYMBOLS = 3;
    localparam int PADDR_W     = 4;

    typedef logic [1:0]            t_sym;
    typedef logic [4:0]            t_count;
    typedef logic [5:0]            t_occ;
    typedef logic [STATE_BITS-1:0] t_idx;
    typedef logic [2:0]            t_log;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_COUNT0 = 2'd0;
    localparam logic [1:0] REG_COUNT1 = 2'd1;
    localparam logic [1:0] REG_COUNT2 = 2'd2;

    // symbol codes
    localparam t_sym SYM0 = 2'd0;
    localparam t_sym SYM1 = 2'd1;
    localparam t_sym SYM2 = 2'd2;

    localparam t_count COUNT_RESET [NUM_SYMBOLS] = '{5'd3, 5'd8, 5'd5};

    typedef struct packed {
        t_sym               decode_symbol;
        logic [2:0]         decode_bits;
        logic [3:0]         decode_base;
        logic [3:0]         encode_index;
        logic [4:0]         encode_state;
        logic signed [8:0]  bit_offset;
        logic signed [4:0]  symbol_start;
        logic               bad_spread;
        logic               table_done;
    } t_result;

    typedef struct packed {
        logic inc;   // bump the counter of decode_symbol
        t_occ next;  // its new value
    } t_occ_upd;

    // priority encoder: floor(log2(v)), zero for v of zero or one
    function automatic t_log floor_log2(input t_occ v);
        t_log r;
        r = '0;
        for (int i = 1; i < $bits(t_occ); i++) begin
            if (v[i]) begin
                r = t_log'(i);
            end
        end
        return r;
    endfunction

    // STATE_BITS - l, floored at zero
    function automatic logic [2:0] sat_bits(input t_log l);
        logic [2:0] r;
        if (4'(l) > 4'(STATE_BITS)) begin
            r = '0;
        end else begin
            r = 3'(4'(STATE_BITS) - 4'(l));
        end
        return r;
    endfunction

endpackage

@@ hdl/tbu_ifs.sv @@
interface tbu_sym_if;
    import tbu_pkg::*;
    logic valid;
    logic ready;
    t_sym spread_symbol;
    modport source (output valid, spread_symbol, input ready);
    modport sink   (input valid, spread_symbol, output ready);
endinterface

interface tbu_tbl_if;
    import tbu_pkg::*;
    logic              valid;
    logic              ready;
    t_sym              decode_symbol;
    logic [2:0]        decode_bits;
    logic [3:0]        decode_base;
    logic [3:0]        encode_index;
    logic [4:0]        encode_state;
    logic signed [8:0] bit_offset;
    logic signed [4:0] symbol_start;
    logic              bad_spread;
    logic              table_done;
    modport source (output valid, decode_symbol, decode_bits, decode_base, encode_index,
                    encode_state, bit_offset, symbol_start, bad_spread, table_done,
                    input ready);
    modport sink   (input valid, decode_symbol, decode_bits, decode_base, encode_index,
                    encode_state, bit_offset, symbol_start, bad_spread, table_done,
                    output ready);
endinterface

@@ hdl/tbu_calc.sv @@
module tbu_calc
    import tbu_pkg::*;
(
    input  t_sym     i_sym,
    input  t_count   i_counts [NUM_SYMBOLS],
    input  t_occ     i_occ    [NUM_SYMBOLS],
    input  t_idx     i_state_index,
    output t_result  o_res,
    output t_occ_upd o_upd
);

    t_count     ls;
    t_count     sum;
    t_occ       x;
    logic       known;
    logic       ok;
    logic [2:0] k;
    logic [2:0] bits;
    logic [8:0] k_term;
    logic [8:0] ls_term;
    logic [4:0] start;
    logic [10:0] x_shift;

    always_comb begin
        known = 1'b1;
        ls    = '0;
        sum   = '0;
        x     = '0;
        case (i_sym)
            SYM0: begin
                ls = i_counts[0];
                x  = i_occ[0];
            end
            SYM1: begin
                ls  = i_counts[1];
                sum = i_counts[0];
                x   = i_occ[1];
            end
            SYM2: begin
                ls  = i_counts[2];
                sum = i_counts[0] + i_counts[1];
                x   = i_occ[2];
            end
            default: known = 1'b0;
        endcase

        k       = sat_bits(floor_log2(t_occ'(ls)));
        k_term  = 9'(k) << (STATE_BITS + 1);
        ls_term = 9'(ls) << k;
        start   = sum - ls;

        ok      = known && (x != '0) && (x < {ls, 1'b0});
        bits    = sat_bits(floor_log2(x));
        x_shift = 11'(x) << bits;

        o_res.decode_symbol = i_sym;
        o_res.decode_bits   = ok ? bits : '0;
        o_res.decode_base   = ok ? 4'(x_shift - 11'(TABLE_SIZE)) : '0;
        o_res.encode_index  = ok ? 4'(6'(start) + x) : '0;
        o_res.encode_state  = 5'(i_state_index) + 5'(TABLE_SIZE);
        o_res.bit_offset    = known ? signed'(k_term - ls_term) : '0;
        o_res.symbol_start  = known ? signed'(start) : '0;
        o_res.bad_spread    = !ok;
        o_res.table_done    = (i_state_index == t_idx'(TABLE_SIZE - 1));

        o_upd.inc  = ok;
        o_upd.next = x + 6'd1;
    end

endmodule

@@ hdl/tans_table_builder_unit.sv @@
// Channel   Dir  Handshake      Payload
// i_sym     in   valid/ready    spread_symbol, one per table state, in state order
// o_tbl     out  valid/ready    decode/encode entry plus per-symbol constants
// APB       in   psel/penable   count_symbol0..2 at 0x0, 0x4, 0x8
//
// One transaction in, one out. Entry math is a single combinational pass
// (priority encode, shift, small adds) straight into a two-slot result queue,
// so a symbol can be taken every cycle while a queue slot is free.
// i_sym.ready drops only when both queue slots hold untaken results.
// Reset (sync, active low): counts 3/8/5, counters loaded with them, state 0.
// Counters reload from the current counts after the last state of a table.
module tans_table_builder_unit
    import tbu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    tbu_sym_if.sink            i_sym,
    tbu_tbl_if.source          o_tbl,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    `include "assert_macros.svh"

    // configuration
    t_count r_count [NUM_SYMBOLS];
    logic   cfg_wr;

    // table-build state
    t_occ   r_occ [NUM_SYMBOLS];
    t_idx   r_state_index;

    // result queue: two slots so input keeps flowing while a result waits
    t_result    r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    t_result  n_res;
    t_occ_upd n_upd;
    logic     acc_in;
    logic     acc_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_COUNT0: prdata = 32'(r_count[0]);
            REG_COUNT1: prdata = 32'(r_count[1]);
            REG_COUNT2: prdata = 32'(r_count[2]);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_COUNT0: r_count[0] <= pwdata[4:0];
                REG_COUNT1: r_count[1] <= pwdata[4:0];
                REG_COUNT2: r_count[2] <= pwdata[4:0];
                default: ;  // no register here
            endcase
        end
    end

    tbu_calc u_calc (
        .i_sym         (i_sym.spread_symbol),
        .i_counts      (r_count),
        .i_occ         (r_occ),
        .i_state_index (r_state_index),
        .o_res         (n_res),
        .o_upd         (n_upd)
    );

    assign i_sym.ready = (r_cnt != 2'd2);
    assign acc_in      = i_sym.valid && i_sym.ready;
    assign o_tbl.valid = (r_cnt != 2'd0);
    assign acc_out     = o_tbl.valid && o_tbl.ready;

    // counters and state index; end of table reloads from live counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SYMBOLS; i++) begin
                r_occ[i] <= t_occ'(COUNT_RESET[i]);
            end
            r_state_index <= '0;
        end else if (acc_in) begin
            if (n_res.table_done) begin
                for (int i = 0; i < NUM_SYMBOLS; i++) begin
                    r_occ[i] <= t_occ'(r_count[i]);
                end
            end else if (n_upd.inc) begin
                r_occ[i_sym.spread_symbol] <= n_upd.next;
            end
            r_state_index <= r_state_index + t_idx'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_q[r_wr] <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (acc_in) begin
                r_wr <= !r_wr;
            end
            if (acc_out) begin
                r_rd <= !r_rd;
            end
            if (acc_in && !acc_out) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (acc_out && !acc_in) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_tbl.decode_symbol = r_q[r_rd].decode_symbol;
    assign o_tbl.decode_bits   = r_q[r_rd].decode_bits;
    assign o_tbl.decode_base   = r_q[r_rd].decode_base;
    assign o_tbl.encode_index  = r_q[r_rd].encode_index;
    assign o_tbl.encode_state  = r_q[r_rd].encode_state;
    assign o_tbl.bit_offset    = r_q[r_rd].bit_offset;
    assign o_tbl.symbol_start  = r_q[r_rd].symbol_start;
    assign o_tbl.bad_spread    = r_q[r_rd].bad_spread;
    assign o_tbl.table_done    = r_q[r_rd].table_done;

    // an overused symbol never yields a decode or encode entry
    `ASSERT_IMPL(a_bad_no_entry, n_res.bad_spread,
        n_res.decode_bits == '0 && n_res.encode_index == '0 && !n_upd.inc)
    // last state wraps the index
    `ASSERT_NEXT(a_wrap, acc_in && n_res.table_done, r_state_index == '0)
    // delivered end-of-table entry carries the top state value
    `ASSERT_IMPL(a_done_state, o_tbl.valid && o_tbl.table_done,
        o_tbl.encode_state == 5'(2 * TABLE_SIZE - 1))
    // queue occupancy tracks the two handshakes
    `ASSERT_NEXT(a_fill, acc_in && !acc_out, r_cnt == $past(r_cnt) + 2'd1)

endmodule
